/* rtl/pfq_pkg.sv */
package pfq_pkg;

   // default queue depth
   localparam int PFQ_DEPTH = 16;

   // action codes
   localparam logic [1:0] ACT_PUSH    = 2'd0;
   localparam logic [1:0] ACT_POP     = 2'd1;
   localparam logic [1:0] ACT_EXTRACT = 2'd2;

   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] entry_id;
      logic [7:0]  entry_priority;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [15:0] out_id;
      logic [7:0]  out_priority;
      logic [4:0]  occupancy;
      logic        overflow;
   } rsp_type;

   // one stored queue entry
   typedef struct packed {
      logic [15:0] id;
      logic [7:0]  prio;
   } entry_type;

   // control into the shared compare unit
   typedef struct packed {
      logic clear;
      logic valid;
   } cmp_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_RESP
   } state_type;

endpackage

/* rtl/pfq_mem.sv */
module pfq_mem #(
   parameter int DEPTH = pfq_pkg::PFQ_DEPTH,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  pfq_pkg::entry_type wr_data,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr,
   output pfq_pkg::entry_type rd_data
);
   import pfq_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/pfq_best.sv */
module pfq_best #(
   parameter int DEPTH = pfq_pkg::PFQ_DEPTH,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  pfq_pkg::cmp_ctl_type ctl,
   input  logic [AW-1:0]        idx,
   input  pfq_pkg::entry_type   data,
   output logic [AW-1:0]        best_idx,
   output pfq_pkg::entry_type   best
);
   import pfq_pkg::*;

   logic          have_ff, have_in;
   logic [AW-1:0] best_idx_ff, best_idx_in;
   entry_type     best_ff, best_in;
   logic          take;

   // keep the first entry on a tie: replace only on strictly greater priority
   always_comb begin
      take        = ctl.valid && (!have_ff || (data.prio > best_ff.prio));
      have_in     = have_ff;
      best_idx_in = best_idx_ff;
      best_in     = best_ff;
      if (ctl.clear) begin
         have_in = 1'b0;
      end else if (take) begin
         have_in     = 1'b1;
         best_idx_in = idx;
         best_in     = data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
      end else begin
         have_ff <= have_in;
      end
   end

   always_ff @(posedge clock) begin
      best_idx_ff <= best_idx_in;
      best_ff     <= best_in;
   end

   assign best_idx = best_idx_ff;
   assign best     = best_ff;

endmodule

/* rtl/fifo_with_priority_extract.sv */
// Push, no-op and removals on an empty queue: result valid in the cycle after the input beat.
// Pop and extract scan, then close the gap; an extract takes longest when the front entry
// wins, as every entry behind it must move. One item at a time; the single memory read port
// reads the entries (only the front one for a pop) to find the removed slot, then the entries
// behind that slot to close the gap. Next input beat is taken the cycle after the result beat.
// Synchronous reset empties the queue; entry storage is not cleared.
module fifo_with_priority_extract #(
   parameter int DEPTH = pfq_pkg::PFQ_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pfq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pfq_pkg::rsp_type rsp_data
);
   import pfq_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   state_type   state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] rd_idx_ff, rd_idx_in;
   logic [CW-1:0] lim_ff, lim_in;
   logic          pend_ff, pend_in;
   logic [AW-1:0] pend_idx_ff, pend_idx_in;
   rsp_type       rsp_ff, rsp_in;

   logic          accept;
   logic          is_push, is_pop, is_rm, empty, full;
   logic          scan_issue, shift_issue, scan_done, shift_done;
   logic          mem_wr_en, mem_rd_en;
   logic [AW-1:0] mem_wr_addr, mem_rd_addr;
   entry_type     mem_wr_data, mem_rd_data;
   cmp_ctl_type   cmp_ctl;
   logic [AW-1:0] best_idx;
   entry_type     best;

   // decode the beat and the queue status
   assign accept      = req_valid && req_ready;
   assign is_push     = (req_data.action == ACT_PUSH);
   assign is_pop      = (req_data.action == ACT_POP);
   assign is_rm       = is_pop || (req_data.action == ACT_EXTRACT);
   assign empty       = (count_ff == '0);
   assign full        = (count_ff >= CW'(DEPTH));
   assign scan_issue  = (state_ff == ST_SCAN) && (rd_idx_ff < lim_ff);
   assign shift_issue = (state_ff == ST_SHIFT) && (rd_idx_ff < count_ff);
   assign scan_done   = (state_ff == ST_SCAN) && !scan_issue && !pend_ff;
   assign shift_done  = (state_ff == ST_SHIFT) && !shift_issue && !pend_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (is_rm && !empty) ? ST_SCAN : ST_RESP;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            if (shift_done) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // handshakes, memory and compare unit control
   always_comb begin
      req_ready     = 1'b0;
      rsp_valid     = 1'b0;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = count_ff[AW-1:0];
      mem_wr_data   = '{id: req_data.entry_id, prio: req_data.entry_priority};
      mem_rd_en     = scan_issue || shift_issue;
      mem_rd_addr   = rd_idx_ff[AW-1:0];
      cmp_ctl.clear = 1'b0;
      cmp_ctl.valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            mem_wr_en     = accept && is_push && !full;
            cmp_ctl.clear = accept;
         end
         ST_SCAN: begin
            cmp_ctl.valid = pend_ff;
         end
         ST_SHIFT: begin
            // move the entry read last cycle one slot toward the front
            mem_wr_en   = pend_ff;
            mem_wr_addr = pend_idx_ff - AW'(1);
            mem_wr_data = mem_rd_data;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      count_in    = count_ff;
      rd_idx_in   = rd_idx_ff;
      lim_in      = lim_ff;
      pend_in     = 1'b0;
      pend_idx_in = rd_idx_ff[AW-1:0];
      rsp_in      = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rd_idx_in = '0;
               lim_in    = is_pop ? CW'(1) : count_ff;
               rsp_in    = '0;
               if (is_push) begin
                  if (full) begin
                     rsp_in.overflow = 1'b1;
                  end else begin
                     count_in = count_ff + CW'(1);
                  end
               end
               rsp_in.occupancy = 5'(count_in);
            end
         end
         ST_SCAN: begin
            pend_in = scan_issue;
            if (scan_issue) begin
               rd_idx_in = rd_idx_ff + CW'(1);
            end
            if (scan_done) begin
               rd_idx_in = CW'(best_idx) + CW'(1);
            end
         end
         ST_SHIFT: begin
            pend_in = shift_issue;
            if (shift_issue) begin
               rd_idx_in = rd_idx_ff + CW'(1);
            end
            if (shift_done) begin
               count_in            = count_ff - CW'(1);
               rsp_in.found        = 1'b1;
               rsp_in.out_id       = best.id;
               rsp_in.out_priority = best.prio;
               rsp_in.occupancy    = 5'(count_in);
               rsp_in.overflow     = 1'b0;
            end
         end
         ST_RESP: begin
            pend_in = 1'b0;
         end
         default: begin
            pend_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      lim_ff      <= lim_in;
      pend_idx_ff <= pend_idx_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_data = rsp_ff;

   pfq_mem #(
      .DEPTH (DEPTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   pfq_best #(
      .DEPTH (DEPTH)
   ) u_best (
      .clock    (clock),
      .reset    (reset),
      .ctl      (cmp_ctl),
      .idx      (pend_idx_ff),
      .data     (mem_rd_data),
      .best_idx (best_idx),
      .best     (best)
   );

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue count above depth");

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input ready while a result is pending");

   a_shift_addr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT) && pend_ff |-> pend_idx_ff != '0)
      else $error("gap close would write below the front slot");

   a_best_in_range: assert property (@(posedge clock) disable iff (reset)
      scan_done |-> CW'(best_idx) < lim_ff)
      else $error("selected slot outside the scanned range");

   a_back_to_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> req_ready)
      else $error("block not idle after result beat");
`endif

endmodule
